FILE: design/bsoc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsoc_pkg: shared types and constants
// Commands, register indexes, FSM states and payload structs of the sphere
// obstacle checker.
// ---------------------------------------------------------------------------
package bsoc_pkg;

	localparam int MAX_OBSTACLES_DEF = 16;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_CHECK = 2'd1,
		CMD_SENSE = 2'd2,
		CMD_MATCH = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_LOWER_X = 3'd0,
		REG_LOWER_Y = 3'd1,
		REG_LOWER_Z = 3'd2,
		REG_UPPER_X = 3'd3,
		REG_UPPER_Y = 3'd4,
		REG_UPPER_Z = 3'd5,
		REG_RADIUS  = 3'd6,
		REG_COUNT   = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec_t;

	// token travelling down the evaluation pipe
	typedef struct packed {
		logic act;   // stage holds a token
		logic live;  // slot is below the obstacle count
		logic tail;  // final token of the sweep
	} tok_t;

	typedef struct packed {
		logic        answer;
		logic        found;
		logic [3:0]  slot;
		vec_t        c;
		logic [30:0] size;
		logic        last;
	} rsp_t;

endpackage

FILE: design/bsoc_ifs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsoc_ifs: channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface bsoc_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [3:0]         slot;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [30:0]        bound_x;
	logic [30:0]        bound_y;
	logic [30:0]        bound_z;
	logic [30:0]        sensor_range;
	logic [30:0]        query_radius;

	modport source (output valid, command, slot, pos_x, pos_y, pos_z, bound_x, bound_y,
		bound_z, sensor_range, query_radius, input ready);
	modport sink (input valid, command, slot, pos_x, pos_y, pos_z, bound_x, bound_y,
		bound_z, sensor_range, query_radius, output ready);
endinterface

interface bsoc_rsp_if;
	logic               valid;
	logic               ready;
	logic               answer;
	logic               obstacle_found;
	logic [3:0]         obstacle_slot;
	logic signed [31:0] obstacle_x;
	logic signed [31:0] obstacle_y;
	logic signed [31:0] obstacle_z;
	logic [30:0]        obstacle_size;
	logic               last;

	modport source (output valid, answer, obstacle_found, obstacle_slot, obstacle_x,
		obstacle_y, obstacle_z, obstacle_size, last, input ready);
	modport sink (input valid, answer, obstacle_found, obstacle_slot, obstacle_x,
		obstacle_y, obstacle_z, obstacle_size, last, output ready);
endinterface

interface bsoc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  addr;
	logic [31:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

FILE: design/bsoc_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsoc_cell: obstacle ring cell
// Holds one obstacle centre; loaded by a write, or from its neighbor while
// the ring rotates during a sweep.
// ---------------------------------------------------------------------------
module bsoc_cell (
	input  logic            clk,
	input  logic            wr_en,
	input  bsoc_pkg::vec_t  wr_data,
	input  logic            shift_en,
	input  bsoc_pkg::vec_t  nbr,
	output bsoc_pkg::vec_t  centre
);
	import bsoc_pkg::*;

	vec_t centre_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			centre_q <= wr_data;
		end else if (shift_en) begin
			centre_q <= nbr;
		end
	end

	assign centre = centre_q;

endmodule

FILE: design/bsoc_eval.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsoc_eval: distance evaluation pipe
// Three stages: per-axis gap, squares, sum vs threshold or centre equality.
// ---------------------------------------------------------------------------
module bsoc_eval #(
	parameter int IW = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  bsoc_pkg::tok_t        tok_in,
	input  logic [IW-1:0]         idx_in,
	input  bsoc_pkg::vec_t        c_in,
	input  bsoc_pkg::cmd_t        cmd,
	input  bsoc_pkg::vec_t        pos,
	input  logic [2:0][30:0]      bnd,
	input  logic [63:0]           thr,
	output bsoc_pkg::tok_t        tok_out,
	output logic [IW-1:0]         idx_out,
	output bsoc_pkg::vec_t        c_out,
	output logic                  hit
);
	import bsoc_pkg::*;

	logic [2:0][31:0] cv, pv, mag;
	logic [2:0][32:0] d, dn;
	logic [2:0][31:0] a;
	logic [2:0][63:0] sq;
	logic [65:0]      sum;

	tok_t             tok_s1, tok_s2, tok_s3;
	logic [IW-1:0]    idx_s1, idx_s2, idx_s3;
	vec_t             c_s1, c_s2, c_s3;
	logic [2:0][31:0] mag_s1;
	logic [2:0][63:0] sq_s2;
	logic             eq_s1, eq_s2, hit_s3;

	assign cv = {c_in.z, c_in.y, c_in.x};
	assign pv = {pos.z, pos.y, pos.x};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d[k]  = {cv[k][31], cv[k]} - {pv[k][31], pv[k]};
			dn[k] = ~d[k] + 33'd1;
			a[k]  = d[k][32] ? dn[k][31:0] : d[k][31:0];
			// box check: distance from the box face, zero inside
			if (cmd == CMD_CHECK) begin
				mag[k] = (a[k] > {1'b0, bnd[k]}) ? a[k] - {1'b0, bnd[k]} : '0;
			end else begin
				mag[k] = a[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sq[k] = mag_s1[k] * mag_s1[k];
		end
	end

	assign sum = {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
			tok_s3 <= '0;
		end else if (en) begin
			tok_s1 <= tok_in;
			tok_s2 <= tok_s1;
			tok_s3 <= tok_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= idx_in;
			c_s1   <= c_in;
			mag_s1 <= mag;
			eq_s1  <= (cv == pv);
			idx_s2 <= idx_s1;
			c_s2   <= c_s1;
			sq_s2  <= sq;
			eq_s2  <= eq_s1;
			idx_s3 <= idx_s2;
			c_s3   <= c_s2;
			hit_s3 <= (cmd == CMD_MATCH) ? eq_s2 : (sum <= {2'b00, thr});
		end
	end

	assign tok_out = tok_s3;
	assign idx_out = idx_s3;
	assign c_out   = c_s3;
	assign hit     = hit_s3;

endmodule

FILE: design/box_sphere_obstacle_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_sphere_obstacle_checker: sphere obstacle table with box/range queries
// Obstacle centres sit in a ring of cells that rotates past one evaluation
// pipe during a query.
// ---------------------------------------------------------------------------
// A write (command 0) loads the addressed cell when accepted. Every other
// command sweeps the whole ring: accept, a setup state, rotation of every
// slot past the pipe, three pipe stages and a final state that loads the
// last result into the output register. The ring rotates one cell per cycle
// while the output is not stalled. Results held by the sink stall the sweep.
// Sense results come out in slot order; the last one carries last = 1.
module box_sphere_obstacle_checker #(
	parameter int MAX_OBSTACLES = bsoc_pkg::MAX_OBSTACLES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	bsoc_cfg_if.sink    cfg,
	bsoc_req_if.sink    req,
	bsoc_rsp_if.source  rsp
);
	import bsoc_pkg::*;

	localparam int IW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int NW = $clog2(MAX_OBSTACLES + 1);

	// configuration
	logic signed [2:0][31:0] lower_q, upper_q;
	logic [30:0]             radius_q;
	logic [4:0]              count_q;

	// query context
	state_t           st_q, st_d;
	cmd_t             cmd_q;
	vec_t             pos_q;
	logic [2:0][30:0] bnd_q;
	logic [31:0]      mag_q;
	logic [63:0]      thr_q;
	logic             rmatch_q, bok_q, flag_q;
	logic [NW-1:0]    n_q, n_w;
	logic [IW-1:0]    cnt_q;

	logic             pend_v_q;
	logic [IW-1:0]    pend_idx_q;
	vec_t             pend_c_q;

	logic             out_valid_q;
	rsp_t             out_q, out_d;

	logic             acc, en, issue, load, pend_load, flag_set, bok_w;
	cmd_t             req_cmd;
	vec_t             cell_c [MAX_OBSTACLES];
	vec_t             req_pos;
	tok_t             tok0, tok3;
	logic [IW-1:0]    idx3;
	vec_t             c3;
	logic             hit3;

	assign cfg.ready = 1'b1;
	assign req_cmd   = cmd_t'(req.command);
	assign req_pos   = '{x: req.pos_x, y: req.pos_y, z: req.pos_z};
	assign req.ready = (st_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign en        = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q  <= '0;
			upper_q  <= '0;
			radius_q <= '0;
			count_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (reg_idx_t'(cfg.addr))
				REG_LOWER_X: lower_q[0] <= cfg.data;
				REG_LOWER_Y: lower_q[1] <= cfg.data;
				REG_LOWER_Z: lower_q[2] <= cfg.data;
				REG_UPPER_X: upper_q[0] <= cfg.data;
				REG_UPPER_Y: upper_q[1] <= cfg.data;
				REG_UPPER_Z: upper_q[2] <= cfg.data;
				REG_RADIUS:  radius_q   <= cfg.data[30:0];
				REG_COUNT:   count_q    <= cfg.data[4:0];
			endcase
		end
	end

	// obstacle ring
	for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
		bsoc_cell u_cell (
			.clk      (clk),
			.wr_en    (acc && (req_cmd == CMD_WRITE) && (int'(req.slot) == i)),
			.wr_data  (req_pos),
			.shift_en (issue),
			.nbr      (cell_c[(i + 1) % MAX_OBSTACLES]),
			.centre   (cell_c[i])
		);
	end

	assign tok0 = '{act: issue, live: (NW'(cnt_q) < n_q),
		tail: (cnt_q == IW'(MAX_OBSTACLES - 1))};

	bsoc_eval #(.IW(IW)) u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tok_in  (tok0),
		.idx_in  (cnt_q),
		.c_in    (cell_c[0]),
		.cmd     (cmd_q),
		.pos     (pos_q),
		.bnd     (bnd_q),
		.thr     (thr_q),
		.tok_out (tok3),
		.idx_out (idx3),
		.c_out   (c3),
		.hit     (hit3)
	);

	assign n_w = (int'(count_q) > MAX_OBSTACLES) ? NW'(MAX_OBSTACLES) : NW'(count_q);

	// box must fit between the workspace bounds
	always_comb begin
		logic signed [33:0] lob, hib, ps;
		logic [2:0][31:0]   pv;
		pv    = {pos_q.z, pos_q.y, pos_q.x};
		bok_w = 1'b1;
		for (int k = 0; k < 3; k++) begin
			lob = $signed({{2{lower_q[k][31]}}, lower_q[k]}) + $signed({3'b000, bnd_q[k]});
			hib = $signed({{2{upper_q[k][31]}}, upper_q[k]}) - $signed({3'b000, bnd_q[k]});
			ps  = $signed({{2{pv[k][31]}}, pv[k]});
			if (ps < lob || ps > hib) begin
				bok_w = 1'b0;
			end
		end
	end

	always_comb begin
		st_d      = st_q;
		issue     = 1'b0;
		load      = 1'b0;
		out_d     = '0;
		pend_load = 1'b0;
		flag_set  = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (acc && req_cmd != CMD_WRITE) begin
					st_d = ST_SETUP;
				end
			end
			ST_SETUP: st_d = ST_RUN;
			ST_RUN: begin
				if (en) begin
					issue = 1'b1;
					if (cnt_q == IW'(MAX_OBSTACLES - 1)) begin
						st_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: ;
			ST_FIN: begin
				if (en) begin
					load      = 1'b1;
					out_d.last = 1'b1;
					st_d      = ST_IDLE;
					unique case (cmd_q)
						CMD_CHECK: out_d.answer = bok_q && !flag_q;
						CMD_MATCH: out_d.answer = rmatch_q && flag_q;
						CMD_SENSE: begin
							if (pend_v_q) begin
								out_d.answer = 1'b1;
								out_d.found  = 1'b1;
								out_d.slot   = 4'(pend_idx_q);
								out_d.c      = pend_c_q;
								out_d.size   = radius_q;
							end
						end
						CMD_WRITE: out_d.answer = 1'b0;
					endcase
				end
			end
			default: st_d = ST_IDLE;
		endcase
		// pipe exit
		if (en && tok3.act) begin
			if (tok3.tail) begin
				st_d = ST_FIN;
			end
			if (tok3.live && hit3) begin
				if (cmd_q == CMD_SENSE) begin
					pend_load = 1'b1;
					// a newer hit proves the held one is not the last
					if (pend_v_q) begin
						load         = 1'b1;
						out_d.answer = 1'b1;
						out_d.found  = 1'b1;
						out_d.slot   = 4'(pend_idx_q);
						out_d.c      = pend_c_q;
						out_d.size   = radius_q;
						out_d.last   = 1'b0;
					end
				end else begin
					flag_set = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			flag_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (acc) begin
				cnt_q    <= '0;
				flag_q   <= 1'b0;
				pend_v_q <= 1'b0;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + IW'(1);
				end
				if (flag_set) begin
					flag_q <= 1'b1;
				end
				if (pend_load) begin
					pend_v_q <= 1'b1;
				end
			end
			if (en) begin
				out_valid_q <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q    <= req_cmd;
			pos_q    <= req_pos;
			bnd_q    <= {req.bound_z, req.bound_y, req.bound_x};
			mag_q    <= (req_cmd == CMD_SENSE) ?
				({1'b0, radius_q} + {1'b0, req.sensor_range}) : {1'b0, radius_q};
			rmatch_q <= (req.query_radius == radius_q);
			n_q      <= n_w;
		end
		if (st_q == ST_SETUP) begin
			thr_q <= mag_q * mag_q;
			bok_q <= bok_w;
		end
		if (pend_load) begin
			pend_idx_q <= idx3;
			pend_c_q   <= c3;
		end
		if (en && load) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.answer         = out_q.answer;
	assign rsp.obstacle_found = out_q.found;
	assign rsp.obstacle_slot  = out_q.slot;
	assign rsp.obstacle_x     = out_q.c.x;
	assign rsp.obstacle_y     = out_q.c.y;
	assign rsp.obstacle_z     = out_q.c.z;
	assign rsp.obstacle_size  = out_q.size;
	assign rsp.last           = out_q.last;

endmodule

FILE: design/bsoc_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsoc_chk: port checker
// Concurrent checks on the top-level channels, bound to the top level.
// ---------------------------------------------------------------------------
module bsoc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_command,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_answer,
	input logic        rsp_found,
	input logic [3:0]  rsp_slot,
	input logic [31:0] rsp_x,
	input logic        rsp_last
);
	import bsoc_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_found_answer: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found |-> rsp_answer)
		else $error("sensed obstacle without answer");

	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_last && rsp_slot == 4'd0 && rsp_x == 32'd0)
		else $error("plain result must be last with zero obstacle fields");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_command != 2'(CMD_WRITE) |=> !req_ready)
		else $error("query transaction did not make the block busy");

endmodule

bind box_sphere_obstacle_checker bsoc_chk u_bsoc_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_command (req.command),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_answer  (rsp.answer),
	.rsp_found   (rsp.obstacle_found),
	.rsp_slot    (rsp.obstacle_slot),
	.rsp_x       (rsp.obstacle_x),
	.rsp_last    (rsp.last)
);
